>>> design/tpd_pkg.sv
`default_nettype none

package tpd_pkg;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 30;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FOUR_BYTE_PIXELS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RUN_LENGTH_CODED = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PIXEL_TOTAL      = 2'd2;

   localparam logic [6:0] HDR_COUNT_MASK = 7'h7f;
   localparam int         HDR_RUN_BIT    = 7;

   localparam logic [2:0] LAST_PHASE_THREE = 3'd2;
   localparam logic [2:0] LAST_PHASE_FOUR  = 3'd3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic four_byte_pixels;
      logic run_length_coded;
   } tpd_mode_type;

   // One entry of the queue between the byte classifier and the pixel counter.
   typedef struct packed {
      logic       start;
      logic       pixel;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] want;
      logic       more_due;
   } tpd_event_type;

   typedef struct packed {
      logic push;
      logic full;
   } tpd_push_type;

   typedef struct packed {
      logic pop;
      logic empty;
   } tpd_pop_type;

endpackage

`default_nettype wire

>>> design/tpd_req_if.sv
`default_nettype none

interface tpd_req_if import tpd_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       image_start;

   modport source (output valid, output data_byte, output image_start, input ready);
   modport sink (input valid, input data_byte, input image_start, output ready);
endinterface

`default_nettype wire

>>> design/tpd_rsp_if.sv
`default_nettype none

interface tpd_rsp_if import tpd_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
   logic [7:0] repeat_count;
   logic       image_last;
   logic       overrun;

   modport source (output valid, output red, output green, output blue, output alpha,
                   output repeat_count, output image_last, output overrun, input ready);
   modport sink (input valid, input red, input green, input blue, input alpha,
                 input repeat_count, input image_last, input overrun, output ready);
endinterface

`default_nettype wire

>>> design/tpd_csr_if.sv
`default_nettype none

interface tpd_csr_if import tpd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/tpd_front.sv
`default_nettype none

module tpd_front import tpd_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire tpd_mode_type  mode,
   tpd_req_if.sink            req,
   input  wire logic          queue_full,
   output logic               push,
   output tpd_event_type      push_event
);

   logic [2:0]  byte_phase_ff, byte_phase_in;
   logic [7:0]  packet_left_ff, packet_left_in;
   logic        packet_is_run_ff, packet_is_run_in;
   logic [23:0] colour_ff, colour_in;

   logic        accept;
   logic [2:0]  phase;
   logic [7:0]  left;
   logic        is_run;
   logic [23:0] colour;
   logic [2:0]  last_phase;
   logic [7:0]  b;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;
   assign b         = req.data_byte;

   always_comb begin
      // A start byte clears the decode position before it is used.
      phase      = req.image_start ? 3'd0  : byte_phase_ff;
      left       = req.image_start ? 8'd0  : packet_left_ff;
      is_run     = req.image_start ? 1'b0  : packet_is_run_ff;
      colour     = req.image_start ? 24'd0 : colour_ff;
      last_phase = mode.four_byte_pixels ? LAST_PHASE_FOUR : LAST_PHASE_THREE;

      byte_phase_in    = phase;
      packet_left_in   = left;
      packet_is_run_in = is_run;
      colour_in        = colour;

      push_event          = '0;
      push_event.start    = req.image_start;
      push_event.want     = 8'd1;
      push_event.green    = colour[15:8];
      push_event.blue     = colour[7:0];
      push_event.red      = mode.four_byte_pixels ? colour[23:16] : b;
      push_event.alpha    = mode.four_byte_pixels ? b : 8'd0;

      if (mode.run_length_coded && (left == 8'd0)) begin
         packet_is_run_in = b[HDR_RUN_BIT];
         packet_left_in   = {1'b0, b[6:0] & HDR_COUNT_MASK} + 8'd1;
         byte_phase_in    = 3'd0;
         colour_in        = 24'd0;
      end else if (phase >= last_phase) begin
         push_event.pixel = 1'b1;
         byte_phase_in    = 3'd0;
         colour_in        = 24'd0;
         if (mode.run_length_coded) begin
            if (is_run) begin
               push_event.want = left;
               packet_left_in  = 8'd0;
            end else begin
               packet_left_in      = left - 8'd1;
               push_event.more_due = (left != 8'd1);
            end
         end
      end else begin
         case (phase)
            3'd0:    colour_in[7:0]   = b;
            3'd1:    colour_in[15:8]  = b;
            default: colour_in[23:16] = b;
         endcase
         byte_phase_in = phase + 3'd1;
      end

      push = accept && (push_event.start || push_event.pixel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_phase_ff    <= '0;
         packet_left_ff   <= '0;
         packet_is_run_ff <= 1'b0;
         colour_ff        <= '0;
      end else if (accept) begin
         byte_phase_ff    <= byte_phase_in;
         packet_left_ff   <= packet_left_in;
         packet_is_run_ff <= packet_is_run_in;
         colour_ff        <= colour_in;
      end
   end

endmodule

`default_nettype wire

>>> design/tpd_queue.sv
`default_nettype none

module tpd_queue import tpd_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire tpd_event_type push_event,
   input  wire logic          pop,
   output tpd_event_type      pop_event,
   output tpd_push_type       push_side,
   output tpd_pop_type        pop_side
);

   tpd_event_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]     count_ff, count_in;

   assign push_side.push  = push;
   assign push_side.full  = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign pop_side.pop    = pop;
   assign pop_side.empty  = (count_ff == '0);
   assign pop_event       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_event;
      end
   end

endmodule

`default_nettype wire

>>> design/tpd_back.sv
`default_nettype none

module tpd_back import tpd_pkg::*; #(
   parameter int PIXEL_COUNT_BITS = 30
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [PIXEL_COUNT_BITS-1:0] pixel_total,
   input  wire tpd_event_type               ev,
   input  wire logic                        queue_empty,
   output logic                             pop,
   tpd_rsp_if.source                        rsp
);

   logic [PIXEL_COUNT_BITS-1:0] pixels_done_ff, pixels_done_in;
   logic                        image_done_ff, image_done_in;
   logic                        out_valid_ff, out_valid_in;
   logic [7:0]                  red_ff, green_ff, blue_ff, alpha_ff, count_ff;
   logic                        last_ff, overrun_ff;

   logic [PIXEL_COUNT_BITS-1:0] done;
   logic                        idone;
   logic [PIXEL_COUNT_BITS-1:0] total;
   logic [PIXEL_COUNT_BITS-1:0] remaining;
   logic [PIXEL_COUNT_BITS-1:0] want_ext;
   logic [7:0]                  cnt;
   logic                        last;
   logic                        overrun;
   logic                        produce;

   assign pop = !queue_empty && (!out_valid_ff || rsp.ready);

   always_comb begin
      done      = ev.start ? '0 : pixels_done_ff;
      idone     = ev.start ? 1'b0 : image_done_ff;
      // A zero total behaves as one pixel.
      total     = (pixel_total == '0) ? PIXEL_COUNT_BITS'(1) : pixel_total;
      remaining = (total > done) ? total - done : PIXEL_COUNT_BITS'(1);
      want_ext  = PIXEL_COUNT_BITS'(ev.want);
      cnt       = (want_ext < remaining) ? ev.want : remaining[7:0];
      last      = (want_ext >= remaining);
      overrun   = (want_ext > remaining) || (last && ev.more_due) || (done >= total);
      produce   = pop && ev.pixel && !idone;

      pixels_done_in = pixels_done_ff;
      image_done_in  = image_done_ff;
      if (pop) begin
         pixels_done_in = done;
         image_done_in  = idone;
         if (produce) begin
            pixels_done_in = done + PIXEL_COUNT_BITS'(cnt);
            image_done_in  = last;
         end
      end

      out_valid_in = out_valid_ff && !rsp.ready;
      if (produce) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixels_done_ff <= '0;
         image_done_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         pixels_done_ff <= pixels_done_in;
         image_done_ff  <= image_done_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         red_ff     <= ev.red;
         green_ff   <= ev.green;
         blue_ff    <= ev.blue;
         alpha_ff   <= ev.alpha;
         count_ff   <= cnt;
         last_ff    <= last;
         overrun_ff <= overrun;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.red          = red_ff;
   assign rsp.green        = green_ff;
   assign rsp.blue         = blue_ff;
   assign rsp.alpha        = alpha_ff;
   assign rsp.repeat_count = count_ff;
   assign rsp.image_last   = last_ff;
   assign rsp.overrun      = overrun_ff;

endmodule

`default_nettype wire

>>> design/tga_pixel_stream_decoder.sv
`default_nettype none

// Channel   Dir  Payload                                              Accepted when
// req_ch    in   data_byte, image_start                               valid && ready
// rsp_ch    out  red, green, blue, alpha, repeat_count, image_last,   valid && ready
//                overrun
// csr_ch    in   index, data                                          valid (ready tied high)
//
// One byte is taken every cycle while the queue is not full. A pixel result is registered
// first in the queue entry and then in the output register before it is valid on rsp_ch.
// The byte classifier pushes into a four-entry queue that the pixel counter drains
// through a registered output, so a stalled result only stops input once the queue fills.
// Reset is synchronous and clears all decode position, queue state and configuration registers
// to their defaults; the pixel data registers are not reset. There is no clearing pass after reset.

module tga_pixel_stream_decoder import tpd_pkg::*; #(
   parameter int PIXEL_COUNT_BITS = 30
) (
   input  wire logic clock,
   input  wire logic reset,
   tpd_req_if.sink   req_ch,
   tpd_rsp_if.source rsp_ch,
   tpd_csr_if.sink   csr_ch
);

   logic                        four_byte_ff;
   logic                        rle_ff;
   logic [PIXEL_COUNT_BITS-1:0] pixel_total_ff;
   logic [31:0]                 csr_ext;
   tpd_mode_type                mode;

   logic                        push;
   tpd_event_type               push_event;
   tpd_event_type               pop_event;
   logic                        pop;
   tpd_push_type                push_side;
   tpd_pop_type                 pop_side;

   assign csr_ch.ready = 1'b1;
   assign csr_ext      = {{(32-CSR_DATA_BITS){1'b0}}, csr_ch.data};

   always_ff @(posedge clock) begin
      if (reset) begin
         four_byte_ff   <= 1'b0;
         rle_ff         <= 1'b0;
         pixel_total_ff <= PIXEL_COUNT_BITS'(1);
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_FOUR_BYTE_PIXELS: four_byte_ff   <= csr_ch.data[0];
            CSR_RUN_LENGTH_CODED: rle_ff         <= csr_ch.data[0];
            CSR_PIXEL_TOTAL:      pixel_total_ff <= csr_ext[PIXEL_COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign mode.four_byte_pixels = four_byte_ff;
   assign mode.run_length_coded = rle_ff;

   tpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode),
      .req        (req_ch),
      .queue_full (push_side.full),
      .push       (push),
      .push_event (push_event)
   );

   tpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_event (push_event),
      .pop        (pop),
      .pop_event  (pop_event),
      .push_side  (push_side),
      .pop_side   (pop_side)
   );

   tpd_back #(
      .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pixel_total (pixel_total_ff),
      .ev          (pop_event),
      .queue_empty (pop_side.empty),
      .pop         (pop),
      .rsp         (rsp_ch)
   );

endmodule

`default_nettype wire

>>> verif/tga_pixel_stream_decoder_test.sv
`default_nettype none

module tga_pixel_stream_decoder_test;
   import tpd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_INDEX = 2'd3;
   localparam int ITEM_TARGET    = 775;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int REPORT_LIMIT   = 40;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] repeat_count;
      logic       image_last;
      logic       overrun;
   } pixel_result_type;

   typedef struct packed {
      logic [7:0] data;
      logic       start;
   } byte_item_type;

   logic clock;
   logic reset;

   tpd_req_if req_ch ();
   tpd_rsp_if rsp_ch ();
   tpd_csr_if csr_ch ();

   tga_pixel_stream_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Decoder mirror: configuration and decode position.
   tpd_mode_type mode;
   logic [29:0]  image_size;
   logic [2:0]   gather_phase;
   logic [7:0]   packet_remaining;
   logic         packet_run;
   logic [23:0]  colour_bytes;
   logic [29:0]  pixel_count;
   logic         image_complete;

   pixel_result_type pixel_queue[$];
   byte_item_type    byte_queue[$];

   logic        start_flag;
   logic        req_fired;
   int          csr_accepts;
   int          bytes_decoded;
   int          mismatches;
   int unsigned req_gap;
   int unsigned req_calm;
   int unsigned rsp_stall;
   int unsigned rsp_calm;
   int unsigned quiet_cycles;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int unsigned seen,
                                  input int unsigned due);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("mismatch on %s: got %0h, expected %0h, at %0t", what, seen, due, $time);
      end
   endtask

   function automatic void clear_position();
      gather_phase     = '0;
      packet_remaining = '0;
      packet_run       = 1'b0;
      colour_bytes     = '0;
      pixel_count      = '0;
      image_complete   = 1'b0;
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic start,
                                       output logic produced, output pixel_result_type px);
      logic [2:0]  final_phase;
      logic [29:0] whole;
      logic [29:0] remaining;
      logic [29:0] want;
      logic [29:0] cnt;
      logic        more_due;
      logic        last;
      produced = 1'b0;
      px = '0;
      more_due = 1'b0;
      final_phase = mode.four_byte_pixels ? LAST_PHASE_FOUR : LAST_PHASE_THREE;
      if (start) clear_position();
      if (image_complete) return;
      if (mode.run_length_coded && packet_remaining == 0) begin
         packet_run = b[HDR_RUN_BIT];
         packet_remaining = {1'b0, b[6:0] & HDR_COUNT_MASK} + 8'd1;
         gather_phase = '0;
         colour_bytes = '0;
         return;
      end
      if (gather_phase < final_phase) begin
         case (gather_phase)
            3'd0: colour_bytes[7:0] = b;
            3'd1: colour_bytes[15:8] = b;
            default: colour_bytes[23:16] = b;
         endcase
         gather_phase = gather_phase + 3'd1;
         return;
      end
      // The closing byte is red in three-byte mode and alpha in four-byte mode.
      px.blue  = colour_bytes[7:0];
      px.green = colour_bytes[15:8];
      px.red   = mode.four_byte_pixels ? colour_bytes[23:16] : b;
      px.alpha = mode.four_byte_pixels ? b : 8'd0;
      want = 30'd1;
      if (mode.run_length_coded) begin
         if (packet_run) begin
            if (packet_remaining != 0) want = {22'd0, packet_remaining};
            packet_remaining = '0;
         end else begin
            if (packet_remaining != 0) packet_remaining = packet_remaining - 8'd1;
            more_due = packet_remaining != 0;
         end
      end
      whole = (image_size == 0) ? 30'd1 : image_size;
      remaining = (whole > pixel_count) ? whole - pixel_count : 30'd1;
      cnt = (want < remaining) ? want : remaining;
      last = cnt >= remaining;
      px.repeat_count = cnt[7:0];
      px.image_last = last;
      px.overrun = (want > remaining) || (last && more_due) || (pixel_count >= whole);
      pixel_count = pixel_count + cnt;
      gather_phase = '0;
      colour_bytes = '0;
      if (last) begin
         image_complete = 1'b1;
         packet_remaining = '0;
         packet_run = 1'b0;
      end
      produced = 1'b1;
   endfunction

   task automatic compare_pixel(input pixel_result_type seen, input pixel_result_type due);
      if (seen.red !== due.red) report_mismatch("red", seen.red, due.red);
      if (seen.green !== due.green) report_mismatch("green", seen.green, due.green);
      if (seen.blue !== due.blue) report_mismatch("blue", seen.blue, due.blue);
      if (seen.alpha !== due.alpha) report_mismatch("alpha", seen.alpha, due.alpha);
      if (seen.repeat_count !== due.repeat_count) begin
         report_mismatch("repeat_count", seen.repeat_count, due.repeat_count);
      end
      if (seen.image_last !== due.image_last) begin
         report_mismatch("image_last", seen.image_last, due.image_last);
      end
      if (seen.overrun !== due.overrun) report_mismatch("overrun", seen.overrun, due.overrun);
   endtask

   function automatic int unsigned pick_gap(inout int unsigned calm_left);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm_left != 0) begin
         calm_left--;
         return 0;
      end
      if (roll == 0) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin : result_monitor
      pixel_result_type seen;
      pixel_result_type due;
      logic             produced;
      if (reset) begin
         mode = '0;
         image_size = 30'd1;
         clear_position();
         pixel_queue.delete();
         req_fired = 1'b0;
      end else begin
         req_fired = req_ch.valid && req_ch.ready;
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_FOUR_BYTE_PIXELS: mode.four_byte_pixels = csr_ch.data[0];
               CSR_RUN_LENGTH_CODED: mode.run_length_coded = csr_ch.data[0];
               CSR_PIXEL_TOTAL:      image_size = csr_ch.data;
               default: ;
            endcase
            csr_accepts++;
         end
         if (req_fired) begin
            if (req_ch.image_start || !image_complete) bytes_decoded++;
            decode_byte(req_ch.data_byte, req_ch.image_start, produced, due);
            if (produced) pixel_queue.push_back(due);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen = {rsp_ch.red, rsp_ch.green, rsp_ch.blue, rsp_ch.alpha,
                    rsp_ch.repeat_count, rsp_ch.image_last, rsp_ch.overrun};
            if (pixel_queue.size() == 0) begin
               report_mismatch("pixel with none pending", 1, 0);
            end else begin
               due = pixel_queue.pop_front();
               compare_pixel(seen, due);
            end
         end
      end
   end

   always @(negedge clock) begin : request_driver
      byte_item_type item;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_fired) begin
         if (req_gap != 0) begin
            req_gap--;
            req_ch.valid <= 1'b0;
         end else if (byte_queue.size() != 0) begin
            item = byte_queue.pop_front();
            req_ch.valid       <= 1'b1;
            req_ch.data_byte   <= item.data;
            req_ch.image_start <= item.start;
            req_gap = pick_gap(req_calm);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_stall != 0) begin
         rsp_stall--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         rsp_stall = pick_gap(rsp_calm);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      int target;
      target = csr_accepts + 1;
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      while (csr_accepts != target) @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Waits for every pixel to come back, then gives the pipeline time to swallow
   // header and colour bytes that produce nothing.
   task automatic settle();
      while (byte_queue.size() != 0 || req_ch.valid || pixel_queue.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic queue_byte(input logic [7:0] b);
      byte_queue.push_back({b, start_flag});
      start_flag = 1'b0;
   endtask

   function automatic logic [7:0] rand_byte();
      int unsigned roll;
      roll = $urandom_range(0, 7);
      if (roll == 0) return 8'h00;
      if (roll == 1) return 8'hff;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic queue_pixel();
      queue_byte(rand_byte());
      queue_byte(rand_byte());
      queue_byte(rand_byte());
      if (mode.four_byte_pixels) queue_byte(rand_byte());
   endtask

   function automatic int unsigned pick_count(input logic run);
      int unsigned roll;
      int unsigned c;
      roll = $urandom_range(0, 99);
      if (roll < 60) c = $urandom_range(1, 4);
      else if (roll < 85) c = $urandom_range(5, 16);
      else if (roll < 95) c = $urandom_range(17, 127);
      else c = 128;
      // Long raw packets are costly in bytes, so most of them are cut down.
      if (!run && c > 16 && $urandom_range(0, 3) != 0) c = $urandom_range(1, 16);
      return c;
   endfunction

   function automatic logic [29:0] pick_total();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 30'($urandom_range(1, 24));
      if (roll < 70) return 30'($urandom_range(25, 160));
      if (roll < 78) return 30'd0;
      if (roll < 84) return 30'd1;
      if (roll < 92) return 30'h3fffffff;
      return 30'($urandom());
   endfunction

   task automatic queue_image(input int unsigned goal);
      int unsigned made;
      int unsigned cnt;
      logic        run;
      logic [6:0]  len_code;
      made = 0;
      while (made < goal) begin
         if (mode.run_length_coded) begin
            run = 1'($urandom_range(0, 1));
            cnt = pick_count(run);
            len_code = 7'(cnt - 1);
            queue_byte({run, len_code});
            if (run) queue_pixel();
            else repeat (cnt) queue_pixel();
            made += cnt;
         end else begin
            queue_pixel();
            made++;
         end
      end
   endtask

   initial begin : stimulus
      int unsigned goal;
      logic        fresh;
      reset = 1'b1;
      clock = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.data_byte = '0;
      req_ch.image_start = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      start_flag = 1'b0;
      csr_accepts = 0;
      bytes_decoded = 0;
      mismatches = 0;
      req_gap = 0;
      req_calm = 0;
      rsp_stall = 0;
      rsp_calm = 0;
      quiet_cycles = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Reset defaults: one three-byte pixel completes the image, the next byte is ignored.
      start_flag = 1'b1;
      queue_byte(8'h00);
      queue_byte(8'hff);
      queue_byte(8'h80);
      queue_byte(8'h55);
      settle();

      // A run of two, then a raw packet of two that overruns a three-pixel image.
      write_csr(CSR_SPARE_INDEX, 30'h3fffffff);
      write_csr(CSR_FOUR_BYTE_PIXELS, 30'd1);
      write_csr(CSR_RUN_LENGTH_CODED, 30'd1);
      write_csr(CSR_PIXEL_TOTAL, 30'd3);
      start_flag = 1'b1;
      queue_byte(8'h81);
      queue_byte(8'hff);
      queue_byte(8'h00);
      queue_byte(8'hff);
      queue_byte(8'h00);
      queue_byte(8'h01);
      queue_byte(8'h00);
      queue_byte(8'hff);
      queue_byte(8'h7f);
      queue_byte(8'h80);
      queue_byte(8'haa);
      settle();

      // A zero total acts as one pixel, so a full-length run is clamped.
      write_csr(CSR_FOUR_BYTE_PIXELS, 30'd0);
      write_csr(CSR_PIXEL_TOTAL, 30'd0);
      start_flag = 1'b1;
      queue_byte(8'hff);
      queue_byte(8'h12);
      queue_byte(8'h34);
      queue_byte(8'h56);
      settle();

      // Pixel size shrinks mid-pixel, RLE is switched on mid-image, and the total is
      // lowered to the number of pixels already given out.
      write_csr(CSR_PIXEL_TOTAL, 30'd4);
      write_csr(CSR_RUN_LENGTH_CODED, 30'd0);
      write_csr(CSR_FOUR_BYTE_PIXELS, 30'd1);
      start_flag = 1'b1;
      queue_byte(8'h01);
      queue_byte(8'h02);
      settle();
      write_csr(CSR_FOUR_BYTE_PIXELS, 30'd0);
      queue_byte(8'h03);
      settle();
      write_csr(CSR_RUN_LENGTH_CODED, 30'd1);
      queue_byte(8'h02);
      settle();
      write_csr(CSR_PIXEL_TOTAL, 30'd1);
      queue_byte(8'h04);
      queue_byte(8'h05);
      queue_byte(8'h06);
      settle();

      while (bytes_decoded < ITEM_TARGET) begin
         if ($urandom_range(0, 2) == 0) write_csr(CSR_FOUR_BYTE_PIXELS, 30'($urandom()));
         if ($urandom_range(0, 2) == 0) write_csr(CSR_RUN_LENGTH_CODED, 30'($urandom()));
         fresh = $urandom_range(0, 3) != 0;
         if (fresh || $urandom_range(0, 5) == 0) write_csr(CSR_PIXEL_TOTAL, pick_total());
         if ($urandom_range(0, 15) == 0) write_csr(CSR_SPARE_INDEX, 30'($urandom()));
         if (image_size == 0) begin
            goal = 1;
         end else if (image_size <= 48 || (mode.run_length_coded && image_size <= 160)) begin
            goal = image_size;
         end else begin
            goal = $urandom_range(1, 24);
         end
         if ($urandom_range(0, 5) == 0) goal = $urandom_range(1, goal);
         start_flag = fresh;
         queue_image(goal);
         if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 5)) queue_byte(rand_byte());
         settle();
      end

      settle();
      if (pixel_queue.size() != 0) begin
         report_mismatch("pixels never delivered", 0, pixel_queue.size());
      end
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
